@@ design/button_edge_autorepeat_tracker_core_macros.svh @@
// assertion macros shared by the tracker checker
// each macro expands to one labeled concurrent assertion clocked by clk, reset by rst
`ifndef BUTTON_EDGE_AUTOREPEAT_TRACKER_CORE_MACROS_SVH
`define BUTTON_EDGE_AUTOREPEAT_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define BET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/bet_pkg.sv @@
// shared types and constants for the button edge / auto-repeat tracker
// no dependencies
`timescale 1ns / 1ps

package bet_pkg;

  // field widths
  localparam int BTN_W   = 16;
  localparam int STK_W   = 8;
  localparam int CNT_W   = 17;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CTL_W   = 2;
  localparam int NUM_W   = 3;

  // controller count and result limit
  localparam int DEF_CONTROLLERS = 4;
  localparam int MAX_OUT         = 4;

  // register reset values
  localparam logic [CFG_W-1:0] RESET_DELAY    = 16'd30;
  localparam logic [CFG_W-1:0] RESET_INTERVAL = 16'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_INTERVAL = 1'b1;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_SNAP   = 1'b1;

  // per-controller working entry
  typedef struct packed {
    logic [BTN_W-1:0]        prev;
    logic signed [CNT_W-1:0] cnt;
    logic [2*STK_W-1:0]      stick;
    logic [BTN_W-1:0]        prs;
    logic [BTN_W-1:0]        rel;
    logic [BTN_W-1:0]        rpt;
  } live_t;

  // per-controller published entry
  typedef struct packed {
    logic [BTN_W-1:0]   buttons;
    logic [BTN_W-1:0]   prs;
    logic [BTN_W-1:0]   rel;
    logic [BTN_W-1:0]   rpt;
    logic [2*STK_W-1:0] stick;
  } pub_t;

endpackage

@@ design/bet_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/button_edge_autorepeat_tracker_core.sv @@
// button edge and auto-repeat tracker, top level
// depends on bet_pkg and bet_ram
// a sample reads its ram entry when accepted, then modifies and writes it back; an error
//   sample or an out-of-range id is handled in the idle state alone
// snapshot: for each controller in turn, a ram read (SNAP_RD), then a publish into the
//   output register (SNAP_WR), which waits while the output register is stalled
// a new item is accepted only in the idle state, after the previous item has finished
// reset: registers go to 30 / 5, valid bits clear so entries read as reset values
`timescale 1ns / 1ps

module button_edge_autorepeat_tracker_core
  import bet_pkg::*;
#(
  parameter int CONTROLLERS = DEF_CONTROLLERS
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic [CTL_W-1:0]        controller_id,
  input  logic [BTN_W-1:0]        new_buttons,
  input  logic signed [STK_W-1:0] stick_x_in,
  input  logic signed [STK_W-1:0] stick_y_in,
  input  logic                    sample_error,
  // output channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CTL_W-1:0]        out_controller,
  output logic                    present,
  output logic [BTN_W-1:0]        buttons_now,
  output logic [BTN_W-1:0]        pressed_seen,
  output logic [BTN_W-1:0]        released_seen,
  output logic [BTN_W-1:0]        repeat_seen,
  output logic signed [STK_W-1:0] stick_x_out,
  output logic signed [STK_W-1:0] stick_y_out,
  output logic [NUM_W-1:0]        connected_count,
  output logic                    last
);

  // only ids that fit the id field can ever be sampled
  localparam int NCTL = (CONTROLLERS < MAX_OUT) ? CONTROLLERS : MAX_OUT;
  localparam int AW   = (NCTL > 1) ? $clog2(NCTL) : 1;
  localparam int LIVE_W = $bits(live_t);
  localparam int PUB_W  = $bits(pub_t);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SAMP    = 4'b0010,
    ST_SNAP_RD = 4'b0100,
    ST_SNAP_WR = 4'b1000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] hold_delay;
  logic [CFG_W-1:0] hold_interval;

  logic [NCTL-1:0] present_vec;
  logic [NCTL-1:0] live_vld;
  logic [NCTL-1:0] pub_vld;

  logic [AW-1:0]      idx;
  logic [AW-1:0]      smp_addr;
  logic [BTN_W-1:0]   smp_btn;
  logic [2*STK_W-1:0] smp_stick;
  logic [NUM_W-1:0]   conn_count;

  logic in_fire;
  logic id_ok;
  logic [AW-1:0] id_addr;
  logic out_free;
  logic [NUM_W-1:0] count_now;

  // ram ports
  logic          live_we;
  logic [AW-1:0] live_waddr;
  live_t         live_wdata;
  logic          live_re;
  logic [AW-1:0] live_raddr;
  logic [LIVE_W-1:0] live_rdata;
  logic          pub_we;
  pub_t          pub_wdata;
  logic          pub_re;
  logic [PUB_W-1:0] pub_rdata;

  // effective entries and sample update
  logic [AW-1:0]           cur_addr;
  live_t                   live_rst;
  live_t                   live_eff;
  pub_t                    pub_eff;
  live_t                   live_upd;
  logic [BTN_W-1:0]        diff;
  logic [BTN_W-1:0]        rep;
  logic signed [CNT_W-1:0] cnt_dec;
  logic                    snap_step;
  logic                    snap_last;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign id_ok    = (int'(controller_id) < NCTL);
  assign id_addr  = controller_id[AW-1:0];
  assign out_free = !out_valid || out_ready;

  // present count over all tracked controllers
  always_comb begin
    count_now = '0;
    for (int i = 0; i < NCTL; i++) begin
      count_now = count_now + NUM_W'(present_vec[i]);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_delay    <= RESET_DELAY;
      hold_interval <= RESET_INTERVAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOLD_DELAY:    hold_delay    <= cfg_data;
        REG_HOLD_INTERVAL: hold_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry selection and reset-value substitution
  assign cur_addr  = (state == ST_SAMP) ? smp_addr : idx;
  assign snap_last = (int'(idx) == NCTL - 1);
  assign snap_step = (state == ST_SNAP_WR) && out_free;

  always_comb begin
    live_rst       = '0;
    live_rst.cnt   = $signed({1'b0, RESET_DELAY});
    live_eff       = live_vld[cur_addr] ? live_t'(live_rdata) : live_rst;
    pub_eff        = pub_vld[cur_addr] ? pub_t'(pub_rdata) : '0;
  end

  // edge detection and auto-repeat counter
  always_comb begin
    diff    = smp_btn ^ live_eff.prev;
    cnt_dec = live_eff.cnt - CNT_W'(1);
    live_upd = live_eff;
    if (diff != '0) begin
      rep          = diff & smp_btn;
      live_upd.cnt = $signed({1'b0, hold_delay});
    end else if (cnt_dec > 0) begin
      rep          = '0;
      live_upd.cnt = cnt_dec;
    end else begin
      rep          = smp_btn;
      live_upd.cnt = $signed({1'b0, hold_interval});
    end
    live_upd.prs   = live_eff.prs | (diff & smp_btn);
    live_upd.rel   = live_eff.rel | (diff & live_eff.prev);
    live_upd.rpt   = live_eff.rpt | rep;
    live_upd.prev  = smp_btn;
    live_upd.stick = smp_stick;
  end

  // ram access control
  always_comb begin
    live_re    = (in_fire && kind == KIND_SAMPLE && id_ok && !sample_error)
                 || (state == ST_SNAP_RD);
    live_raddr = (state == ST_SNAP_RD) ? idx : id_addr;
    pub_re     = (state == ST_SNAP_RD);
    live_waddr = cur_addr;
    live_we    = (state == ST_SAMP) || (snap_step && present_vec[idx]);
    pub_we     = snap_step && present_vec[idx];
    if (state == ST_SAMP) begin
      live_wdata = live_upd;
    end else begin
      live_wdata     = live_eff;
      live_wdata.prs = '0;
      live_wdata.rel = '0;
      live_wdata.rpt = '0;
    end
    pub_wdata.buttons = live_eff.prev;
    pub_wdata.prs     = live_eff.prs;
    pub_wdata.rel     = live_eff.rel;
    pub_wdata.rpt     = live_eff.rpt;
    pub_wdata.stick   = live_eff.stick;
  end

  bet_ram #(
    .WIDTH(LIVE_W),
    .DEPTH(NCTL)
  ) u_live_ram (
    .clk  (clk),
    .we   (live_we),
    .waddr(live_waddr),
    .wdata(live_wdata),
    .re   (live_re),
    .raddr(live_raddr),
    .rdata(live_rdata)
  );

  bet_ram #(
    .WIDTH(PUB_W),
    .DEPTH(NCTL)
  ) u_pub_ram (
    .clk  (clk),
    .we   (pub_we),
    .waddr(idx),
    .wdata(pub_wdata),
    .re   (pub_re),
    .raddr(idx),
    .rdata(pub_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      present_vec <= '0;
      live_vld    <= '0;
      pub_vld     <= '0;
      idx         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (kind == KIND_SNAP) begin
              idx   <= '0;
              state <= ST_SNAP_RD;
            end else if (id_ok) begin
              if (sample_error) begin
                present_vec[id_addr] <= 1'b0;
              end else begin
                state <= ST_SAMP;
              end
            end
          end
        end
        ST_SAMP: begin
          present_vec[smp_addr] <= 1'b1;
          live_vld[smp_addr]    <= 1'b1;
          state                 <= ST_IDLE;
        end
        ST_SNAP_RD: begin
          state <= ST_SNAP_WR;
        end
        ST_SNAP_WR: begin
          if (out_free) begin
            if (present_vec[idx]) begin
              pub_vld[idx] <= 1'b1;
            end
            if (snap_last) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= ST_SNAP_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_addr   <= id_addr;
      smp_btn    <= new_buttons;
      smp_stick  <= {stick_y_in, stick_x_in};
      conn_count <= count_now;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_step) begin
      out_controller  <= CTL_W'(idx);
      present         <= present_vec[idx];
      connected_count <= conn_count;
      last            <= snap_last;
      if (present_vec[idx]) begin
        buttons_now   <= live_eff.prev;
        pressed_seen  <= live_eff.prs;
        released_seen <= live_eff.rel;
        repeat_seen   <= live_eff.rpt;
        stick_x_out   <= $signed(live_eff.stick[STK_W-1:0]);
        stick_y_out   <= $signed(live_eff.stick[2*STK_W-1:STK_W]);
      end else begin
        buttons_now   <= pub_eff.buttons;
        pressed_seen  <= pub_eff.prs;
        released_seen <= pub_eff.rel;
        repeat_seen   <= pub_eff.rpt;
        stick_x_out   <= $signed(pub_eff.stick[STK_W-1:0]);
        stick_y_out   <= $signed(pub_eff.stick[2*STK_W-1:STK_W]);
      end
    end
  end

endmodule

@@ design/bet_chk.sv @@
// port-level checker for the tracker top level, with its bind
// depends on bet_pkg and button_edge_autorepeat_tracker_core_macros.svh
`timescale 1ns / 1ps
`include "button_edge_autorepeat_tracker_core_macros.svh"

module bet_chk
  import bet_pkg::*;
#(
  parameter int CONTROLLERS = DEF_CONTROLLERS
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              kind,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CTL_W-1:0]  out_controller,
  input logic [BTN_W-1:0]  buttons_now,
  input logic [NUM_W-1:0]  connected_count,
  input logic              last
);

  localparam int NCTL = (CONTROLLERS < MAX_OUT) ? CONTROLLERS : MAX_OUT;

  // a stalled result holds
  `BET_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(buttons_now) && $stable(out_controller), "stalled result changed")

  // last marks the final controller of a run
  `BET_ASSERT_NOW(a_last_ctl, out_valid, last == (int'(out_controller) == NCTL - 1), "last flag does not match controller")

  // count never exceeds the tracked controllers
  `BET_ASSERT_NOW(a_count_max, out_valid, int'(connected_count) <= NCTL, "connected count too large")

  // a snapshot transfer occupies the block
  `BET_ASSERT_NEXT(a_snap_busy, in_valid && in_ready && kind == KIND_SNAP, !in_ready, "ready right after snapshot")

  // a sample never produces a result
  `BET_ASSERT_NEXT(a_samp_quiet, in_valid && in_ready && kind == KIND_SAMPLE, !$rose(out_valid), "result after sample")

endmodule

bind button_edge_autorepeat_tracker_core bet_chk #(.CONTROLLERS(CONTROLLERS)) u_bet_chk (.*);

@@ dv/tb_button_edge_autorepeat_tracker_core.sv @@
`timescale 1ns / 1ps
// self-checking testbench for button_edge_autorepeat_tracker_core: directed and random
// controller samples and snapshots, snapshot results checked against an in-bench predictor
// depends on bet_pkg and the tracker rtl

module tb_button_edge_autorepeat_tracker_core;
  import bet_pkg::*;

  localparam int NUM_CTL          = DEF_CONTROLLERS;
  localparam int NUM_RESULTS      = (NUM_CTL < MAX_OUT) ? NUM_CTL : MAX_OUT;
  localparam int NUM_PHASES       = 6;
  localparam int RANDOM_PER_PHASE = 78;
  localparam int DRAIN_CYCLES     = 12;
  localparam int STALL_LIMIT      = 4000;
  localparam int REPORT_MAX       = 10;

  // one pending input transfer
  typedef struct packed {
    logic               kind;
    logic [CTL_W-1:0]   id;
    logic [BTN_W-1:0]   btn;
    logic [STK_W-1:0]   sx;
    logic [STK_W-1:0]   sy;
    logic               err;
  } feed_item_t;

  // one snapshot result
  typedef struct packed {
    logic [CTL_W-1:0]   ctl;
    logic               pres;
    logic [BTN_W-1:0]   btn;
    logic [BTN_W-1:0]   prs;
    logic [BTN_W-1:0]   rel;
    logic [BTN_W-1:0]   rpt;
    logic [STK_W-1:0]   sx;
    logic [STK_W-1:0]   sy;
    logic [NUM_W-1:0]   cnt;
    logic               lst;
  } snap_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    kind = KIND_SAMPLE;
  logic [CTL_W-1:0]        controller_id = '0;
  logic [BTN_W-1:0]        new_buttons = '0;
  logic signed [STK_W-1:0] stick_x_in = '0;
  logic signed [STK_W-1:0] stick_y_in = '0;
  logic                    sample_error = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [CTL_W-1:0]        out_controller;
  logic                    present;
  logic [BTN_W-1:0]        buttons_now;
  logic [BTN_W-1:0]        pressed_seen;
  logic [BTN_W-1:0]        released_seen;
  logic [BTN_W-1:0]        repeat_seen;
  logic signed [STK_W-1:0] stick_x_out;
  logic signed [STK_W-1:0] stick_y_out;
  logic [NUM_W-1:0]        connected_count;
  logic                    last;

  button_edge_autorepeat_tracker_core #(.CONTROLLERS(NUM_CTL)) u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .controller_id(controller_id),
    .new_buttons(new_buttons), .stick_x_in(stick_x_in), .stick_y_in(stick_y_in),
    .sample_error(sample_error),
    .out_valid(out_valid), .out_ready(out_ready), .out_controller(out_controller),
    .present(present), .buttons_now(buttons_now), .pressed_seen(pressed_seen),
    .released_seen(released_seen), .repeat_seen(repeat_seen), .stick_x_out(stick_x_out),
    .stick_y_out(stick_y_out), .connected_count(connected_count), .last(last)
  );

  feed_item_t   item_feed_q[$];
  snap_result_t snap_expect_q[$];
  feed_item_t   drive_item;
  logic         in_taken = 1'b0;
  int           items_pushed = 0;
  int           items_accepted = 0;
  int           error_count = 0;
  int           idle_cycles = 0;
  int           sender_idle_pct = 0;
  int           receiver_idle_pct = 0;
  logic [BTN_W-1:0] gen_last[NUM_CTL];

  // predicted state of the block
  logic [CFG_W-1:0] delay_reg;
  logic [CFG_W-1:0] interval_reg;
  logic [BTN_W-1:0] held_btn[NUM_CTL];
  int               hold_count[NUM_CTL];
  logic [STK_W-1:0] cur_sx[NUM_CTL];
  logic [STK_W-1:0] cur_sy[NUM_CTL];
  logic [BTN_W-1:0] acc_prs[NUM_CTL];
  logic [BTN_W-1:0] acc_rel[NUM_CTL];
  logic [BTN_W-1:0] acc_rpt[NUM_CTL];
  logic             is_absent[NUM_CTL];
  logic [BTN_W-1:0] pub_btn[NUM_CTL];
  logic [BTN_W-1:0] pub_prs[NUM_CTL];
  logic [BTN_W-1:0] pub_rel[NUM_CTL];
  logic [BTN_W-1:0] pub_rpt[NUM_CTL];
  logic [STK_W-1:0] pub_sx[NUM_CTL];
  logic [STK_W-1:0] pub_sy[NUM_CTL];

  initial begin
    forever #1 clk = ~clk;
  end

  // edge detection and auto-repeat for one answered sample
  task automatic track_sample(input int c, input logic [BTN_W-1:0] b,
                              input logic [STK_W-1:0] x, input logic [STK_W-1:0] y);
    logic [BTN_W-1:0] diff;
    logic [BTN_W-1:0] rep;
    diff = b ^ held_btn[c];
    is_absent[c] = 1'b0;
    if (diff != '0) begin
      rep = diff & b;
      hold_count[c] = int'(delay_reg);
    end else begin
      hold_count[c] = hold_count[c] - 1;
      if (hold_count[c] > 0) begin
        rep = '0;
      end else begin
        rep = b;
        hold_count[c] = int'(interval_reg);
      end
    end
    acc_prs[c] = acc_prs[c] | (diff & b);
    acc_rel[c] = acc_rel[c] | (diff & held_btn[c]);
    acc_rpt[c] = acc_rpt[c] | rep;
    held_btn[c] = b;
    cur_sx[c] = x;
    cur_sy[c] = y;
  endtask

  // present controllers publish and clear, then one result per controller
  task automatic publish_snapshot();
    snap_result_t r;
    int n;
    n = 0;
    for (int i = 0; i < NUM_CTL; i++) begin
      if (!is_absent[i]) begin
        pub_btn[i] = held_btn[i];
        pub_prs[i] = acc_prs[i];
        pub_rel[i] = acc_rel[i];
        pub_rpt[i] = acc_rpt[i];
        pub_sx[i] = cur_sx[i];
        pub_sy[i] = cur_sy[i];
        acc_prs[i] = '0;
        acc_rel[i] = '0;
        acc_rpt[i] = '0;
        n++;
      end
    end
    if (n > 7) n = 7;
    for (int i = 0; i < NUM_RESULTS; i++) begin
      r.ctl  = CTL_W'(i);
      r.pres = !is_absent[i];
      r.btn  = pub_btn[i];
      r.prs  = pub_prs[i];
      r.rel  = pub_rel[i];
      r.rpt  = pub_rpt[i];
      r.sx   = pub_sx[i];
      r.sy   = pub_sy[i];
      r.cnt  = NUM_W'(n);
      r.lst  = (i == NUM_RESULTS - 1);
      snap_expect_q.push_back(r);
    end
  endtask

  function automatic string describe(snap_result_t r);
    return $sformatf("ctl %0d pres %0d btn %h prs %h rel %h rpt %h x %h y %h cnt %0d last %0d",
                     r.ctl, r.pres, r.btn, r.prs, r.rel, r.rpt, r.sx, r.sy, r.cnt, r.lst);
  endfunction

  // compare one output transfer with the oldest expected result
  task automatic check_snapshot_result();
    snap_result_t got;
    snap_result_t want;
    got.ctl  = out_controller;
    got.pres = present;
    got.btn  = buttons_now;
    got.prs  = pressed_seen;
    got.rel  = released_seen;
    got.rpt  = repeat_seen;
    got.sx   = stick_x_out;
    got.sy   = stick_y_out;
    got.cnt  = connected_count;
    got.lst  = last;
    if (snap_expect_q.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_MAX) $display("unexpected result: %s", describe(got));
    end else begin
      want = snap_expect_q.pop_front();
      if (got.ctl !== want.ctl || got.pres !== want.pres || got.btn !== want.btn ||
          got.prs !== want.prs || got.rel !== want.rel || got.rpt !== want.rpt ||
          got.sx !== want.sx || got.sy !== want.sy || got.cnt !== want.cnt ||
          got.lst !== want.lst) begin
        error_count++;
        if (error_count <= REPORT_MAX) begin
          $display("result mismatch\n  expected %s\n  actual   %s",
                   describe(want), describe(got));
        end
      end
    end
  endtask

  // predictor and result checker
  always @(posedge clk) begin
    if (rst) begin
      delay_reg = RESET_DELAY;
      interval_reg = RESET_INTERVAL;
      for (int i = 0; i < NUM_CTL; i++) begin
        held_btn[i] = '0;
        hold_count[i] = int'(RESET_DELAY);
        cur_sx[i] = '0;
        cur_sy[i] = '0;
        acc_prs[i] = '0;
        acc_rel[i] = '0;
        acc_rpt[i] = '0;
        is_absent[i] = 1'b1;
        pub_btn[i] = '0;
        pub_prs[i] = '0;
        pub_rel[i] = '0;
        pub_rpt[i] = '0;
        pub_sx[i] = '0;
        pub_sy[i] = '0;
      end
      in_taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HOLD_DELAY) delay_reg = cfg_data;
        else interval_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        items_accepted++;
        if (kind == KIND_SNAP) begin
          publish_snapshot();
        end else if (controller_id < NUM_CTL) begin
          if (sample_error) is_absent[controller_id] = 1'b1;
          else track_sample(int'(controller_id), new_buttons, stick_x_in, stick_y_in);
        end
      end
      if (out_valid && out_ready) check_snapshot_result();
      in_taken <= in_valid && in_ready;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // input driver: holds the item until transferred, then maybe idles
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (item_feed_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        drive_item = item_feed_q.pop_front();
        in_valid <= 1'b1;
        kind <= drive_item.kind;
        controller_id <= drive_item.id;
        new_buttons <= drive_item.btn;
        stick_x_in <= drive_item.sx;
        stick_y_in <= drive_item.sy;
        sample_error <= drive_item.err;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  task automatic add_item(input logic k, input logic [CTL_W-1:0] c,
                          input logic [BTN_W-1:0] b, input logic [STK_W-1:0] x,
                          input logic [STK_W-1:0] y, input logic e);
    feed_item_t it;
    it.kind = k;
    it.id = c;
    it.btn = b;
    it.sx = x;
    it.sy = y;
    it.err = e;
    if (k == KIND_SAMPLE && !e) gen_last[c] = b;
    item_feed_q.push_back(it);
    items_pushed++;
  endtask

  // runs with hold delay 2 and interval 0
  task automatic add_directed();
    // snapshot straight after reset: all absent, nothing published
    add_item(KIND_SNAP, 2'd0, 16'h0000, 8'h00, 8'h00, 1'b0);
    add_item(KIND_SAMPLE, 2'd0, 16'hFFFF, 8'h80, 8'h7F, 1'b0);
    // unchanged zero word, counter only decrements
    add_item(KIND_SAMPLE, 2'd1, 16'h0000, 8'h7F, 8'h80, 1'b0);
    // no answer from a controller
    add_item(KIND_SAMPLE, 2'd2, 16'h1234, 8'h01, 8'hFF, 1'b1);
    add_item(KIND_SAMPLE, 2'd3, 16'h8001, 8'hFF, 8'h00, 1'b0);
    // snapshot with ignored fields all high
    add_item(KIND_SNAP, 2'd3, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    // held word runs out the delay, then repeats every sample with zero interval
    add_item(KIND_SAMPLE, 2'd0, 16'hFFFF, 8'h00, 8'h00, 1'b0);
    add_item(KIND_SAMPLE, 2'd0, 16'hFFFF, 8'h10, 8'h20, 1'b0);
    add_item(KIND_SAMPLE, 2'd0, 16'hFFFF, 8'h30, 8'h40, 1'b0);
    add_item(KIND_SAMPLE, 2'd0, 16'h0000, 8'h80, 8'h80, 1'b0);
    // present controller drops out and keeps its last published values
    add_item(KIND_SAMPLE, 2'd1, 16'hFFFF, 8'h55, 8'hAA, 1'b1);
    add_item(KIND_SNAP, 2'd1, 16'h0000, 8'h00, 8'h00, 1'b0);
    add_item(KIND_SAMPLE, 2'd3, 16'h5555, 8'h7F, 8'h7F, 1'b0);
    add_item(KIND_SAMPLE, 2'd3, 16'hAAAA, 8'h80, 8'h80, 1'b0);
    // back-to-back snapshots, accumulators already cleared by the first
    add_item(KIND_SNAP, 2'd2, 16'h0F0F, 8'h00, 8'h00, 1'b0);
    add_item(KIND_SNAP, 2'd0, 16'hF0F0, 8'h00, 8'h00, 1'b0);
    add_item(KIND_SAMPLE, 2'd2, 16'hFFFF, 8'h00, 8'hFF, 1'b0);
    add_item(KIND_SAMPLE, 2'd2, 16'hFFFF, 8'hFF, 8'h00, 1'b0);
    add_item(KIND_SAMPLE, 2'd2, 16'hFFFF, 8'h01, 8'h02, 1'b0);
    add_item(KIND_SAMPLE, 2'd1, 16'h0001, 8'h03, 8'h04, 1'b0);
    add_item(KIND_SNAP, 2'd3, 16'h0000, 8'h00, 8'h00, 1'b0);
  endtask

  // mostly held or lightly changed words so the repeat counter runs out
  task automatic add_random_items(input int n);
    int pick;
    int c;
    logic [BTN_W-1:0] b;
    logic [BTN_W-1:0] m;
    logic [STK_W-1:0] x;
    logic [STK_W-1:0] y;
    for (int k = 0; k < n; k++) begin
      c = $urandom_range(0, NUM_CTL - 1);
      b = BTN_W'($urandom);
      m = BTN_W'($urandom);
      x = STK_W'($urandom);
      y = STK_W'($urandom);
      if ($urandom_range(0, 99) < 12) begin
        add_item(KIND_SNAP, CTL_W'(c), b, x, y, 1'($urandom_range(0, 1)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) b = gen_last[c];
        else if (pick < 80) b = gen_last[c] ^ (16'h0001 << $urandom_range(0, BTN_W - 1));
        else if (pick < 90) b = gen_last[c] ^ (b & m);
        add_item(KIND_SAMPLE, CTL_W'(c), b, x, y, $urandom_range(0, 99) < 8);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sequence of phases: settings, idling, stimulus, drain
  initial begin
    logic [CFG_W-1:0] d;
    logic [CFG_W-1:0] v;
    for (int i = 0; i < NUM_CTL; i++) gen_last[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin d = 16'd2; v = 16'd0; end
        1: begin d = 16'd3; v = 16'd1; end
        2: begin d = 16'd0; v = 16'd0; end
        3: begin d = 16'hFFFF; v = 16'hFFFF; end
        4: begin d = 16'd4; v = 16'd2; end
        default: begin
          d = CFG_W'($urandom_range(0, 5));
          v = CFG_W'($urandom_range(0, 3));
        end
      endcase
      @(negedge clk);
      if (phase < 2) begin
        sender_idle_pct <= 30;
        receiver_idle_pct <= 52;
      end else if (phase < 4) begin
        sender_idle_pct <= 52;
        receiver_idle_pct <= 30;
      end else begin
        sender_idle_pct <= 0;
        receiver_idle_pct <= 0;
      end
      write_reg(REG_HOLD_DELAY, d);
      write_reg(REG_HOLD_INTERVAL, v);
      if (phase == 0) add_directed();
      else add_random_items(RANDOM_PER_PHASE);
      // sender holds off until every expected result has been transferred
      while (items_accepted != items_pushed || snap_expect_q.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    error_count = error_count + snap_expect_q.size();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/bet_pkg.sv
design/bet_ram.sv
design/button_edge_autorepeat_tracker_core.sv
design/bet_chk.sv
dv/tb_button_edge_autorepeat_tracker_core.sv
